// ===== design/rwt_pkg.sv =====
// rwt_pkg: shared types, widths and constants of the radial warm tint pixel block
// no dependencies; imported by every module of the block
package rwt_pkg;

  // field widths
  localparam int COORD_BITS   = 12;
  localparam int COLOR_BITS   = 8;
  localparam int CENTER_BITS  = 16;
  localparam int INV_BITS     = 24;
  localparam int CFG_BITS     = 24;
  localparam int CFG_IDX_BITS = 2;

  // distance datapath
  localparam int POS_BITS  = COORD_BITS + 4;
  localparam int DIFF_BITS = (POS_BITS > CENTER_BITS) ? POS_BITS : CENTER_BITS;
  localparam int SQ_BITS   = 2 * DIFF_BITS;
  localparam int SUM_BITS  = SQ_BITS + 1;
  localparam int ROOT_BITS = DIFF_BITS + 1;

  // intensity and blend datapath
  localparam int PROD_BITS = ROOT_BITS + INV_BITS;
  localparam int P_SHIFT   = 12;
  localparam int INT_BITS  = 17;
  localparam int Q16_BITS  = 17;
  localparam int WARM_BITS = COLOR_BITS + Q16_BITS;
  localparam int ACC_BITS  = COLOR_BITS + 18;

  localparam logic [INT_BITS-1:0]   ONE_Q16    = INT_BITS'(65536);
  localparam logic [COLOR_BITS-1:0] FULL_SCALE = '1;

  localparam logic [Q16_BITS-1:0] WARM_RED_Q16   = Q16_BITS'(78643);
  localparam logic [Q16_BITS-1:0] WARM_GREEN_Q16 = Q16_BITS'(39322);
  localparam logic [Q16_BITS-1:0] WARM_BLUE_Q16  = Q16_BITS'(6554);

  localparam logic [WARM_BITS-1:0] WARM_RED   =
    WARM_BITS'(FULL_SCALE) * WARM_BITS'(WARM_RED_Q16);
  localparam logic [WARM_BITS-1:0] WARM_GREEN =
    WARM_BITS'(FULL_SCALE) * WARM_BITS'(WARM_GREEN_Q16);
  localparam logic [WARM_BITS-1:0] WARM_BLUE  =
    WARM_BITS'(FULL_SCALE) * WARM_BITS'(WARM_BLUE_Q16);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_INV_DIST = CFG_IDX_BITS'(2);

  localparam logic [CENTER_BITS-1:0] CENTER_RESET = CENTER_BITS'(32768);
  localparam logic [INV_BITS-1:0]    INV_RESET    = INV_BITS'(5793);

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [COLOR_BITS-1:0] in_red;
    logic [COLOR_BITS-1:0] in_green;
    logic [COLOR_BITS-1:0] in_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] out_red;
    logic [COLOR_BITS-1:0] out_green;
    logic [COLOR_BITS-1:0] out_blue;
  } pixel_out_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [CENTER_BITS-1:0] center_x;
    logic [CENTER_BITS-1:0] center_y;
    logic [INV_BITS-1:0]    inv_max_distance;
  } cfg_t;

  // word handed from cell to cell of the square root row
  typedef struct packed {
    logic [SUM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
    color_t               color;
  } root_word_t;

endpackage

// ===== design/rwt_front.sv =====
// rwt_front: offsets from the centre, their squares and the squared distance
// depends on rwt_pkg; feeds the first cell of the square root row
module rwt_front
  import rwt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  pixel_in_t  data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output root_word_t data_o
);

  logic [2:0] v_q;
  logic [2:0] rdy;

  logic [POS_BITS-1:0]  pos_x, pos_y;
  logic [DIFF_BITS-1:0] ax, ay, cx, cy;
  logic [DIFF_BITS-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [SQ_BITS-1:0]   sqx_d, sqy_d, sqx_q, sqy_q;
  logic [SUM_BITS-1:0]  sum_d, sum_q;
  color_t               col_a_q, col_b_q, col_c_q;

  // a stage takes a word when it is empty or its word moves on
  assign rdy[2]  = !v_q[2] || ready_i;
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];

  assign pos_x = {data_i.column, 4'b0000};
  assign pos_y = {data_i.row, 4'b0000};
  assign ax    = DIFF_BITS'(pos_x);
  assign ay    = DIFF_BITS'(pos_y);
  assign cx    = DIFF_BITS'(cfg_i.center_x);
  assign cy    = DIFF_BITS'(cfg_i.center_y);

  assign dx_d  = (ax >= cx) ? (ax - cx) : (cx - ax);
  assign dy_d  = (ay >= cy) ? (ay - cy) : (cy - ay);
  assign sqx_d = SQ_BITS'(dx_q) * SQ_BITS'(dx_q);
  assign sqy_d = SQ_BITS'(dy_q) * SQ_BITS'(dy_q);
  assign sum_d = SUM_BITS'(sqx_q) + SUM_BITS'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      col_a_q <= '{red: data_i.in_red, green: data_i.in_green, blue: data_i.in_blue};
    end
    if (rdy[1] && v_q[0]) begin
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      col_b_q <= col_a_q;
    end
    if (rdy[2] && v_q[1]) begin
      sum_q   <= sum_d;
      col_c_q <= col_b_q;
    end
  end

  assign valid_o     = v_q[2];
  assign data_o.rem   = sum_q;
  assign data_o.root  = '0;
  assign data_o.color = col_c_q;

endmodule

// ===== design/rwt_root_cell.sv =====
// rwt_root_cell: one cell of the square root row, settles one root bit
// depends on rwt_pkg; chained cell to cell from the top root bit down
module rwt_root_cell
  import rwt_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  root_word_t data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output root_word_t data_o
);

  localparam int TW = SUM_BITS + 1;

  logic          v_q;
  logic [TW-1:0] trial;
  logic          take;
  root_word_t    word_d, word_q;

  // (root + b)^2 - root^2 = root * 2b + b^2 with b = 2^BIT
  assign trial = (TW'(data_i.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign take  = {1'b0, data_i.rem} >= trial;

  always_comb begin
    word_d = data_i;
    if (take) begin
      word_d.rem  = data_i.rem - trial[SUM_BITS-1:0];
      word_d.root = data_i.root | (ROOT_BITS'(1) << BIT);
    end
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = word_q;

endmodule

// ===== design/rwt_back.sv =====
// rwt_back: intensity from the distance, blend toward the warm colour, saturate
// depends on rwt_pkg; takes the word from the last square root cell
module rwt_back
  import rwt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  root_word_t data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output pixel_out_t data_o
);

  localparam int PB = PROD_BITS - P_SHIFT;
  localparam int WX = WARM_BITS + INT_BITS;
  localparam int RB = ACC_BITS - 16;

  localparam logic [2:0][WARM_BITS-1:0] WARM = {WARM_BLUE, WARM_GREEN, WARM_RED};

  logic [3:0] v_q;
  logic [3:0] rdy;

  logic [PROD_BITS-1:0] prod_d, prod_q;
  logic [PB-1:0]        p;
  logic [INT_BITS-1:0]  inten_d, inten_q;
  color_t               col_p_q, col_i_q;

  logic [2:0][COLOR_BITS-1:0] chan;
  logic [2:0][ACC_BITS-1:0]   keep_d, keep_q, warm_d, warm_q;
  logic [2:0][ACC_BITS-1:0]   rounded;
  logic [2:0][RB-1:0]         shifted;
  logic [2:0][COLOR_BITS-1:0] sat_d, sat_q;
  logic [WX-1:0]              warm_full [3];

  assign rdy[3]  = !v_q[3] || ready_i;
  assign rdy[2]  = !v_q[2] || rdy[3];
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];

  assign prod_d = PROD_BITS'(data_i.root) * PROD_BITS'(cfg_i.inv_max_distance);

  // intensity clamps to zero once the scaled distance reaches one
  assign p       = prod_q[PROD_BITS-1:P_SHIFT];
  assign inten_d = (p < PB'(ONE_Q16)) ? (ONE_Q16 - p[INT_BITS-1:0]) : '0;

  assign chan[0] = col_i_q.red;
  assign chan[1] = col_i_q.green;
  assign chan[2] = col_i_q.blue;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      keep_d[c]    = ACC_BITS'(chan[c]) * ACC_BITS'(ONE_Q16 - inten_q);
      warm_full[c] = WX'(WARM[c]) * WX'(inten_q);
      warm_d[c]    = ACC_BITS'(warm_full[c] >> 16);
      rounded[c]   = keep_q[c] + warm_q[c] + ACC_BITS'(32768);
      shifted[c]   = rounded[c][ACC_BITS-1:16];
      sat_d[c]     = (shifted[c] > RB'(FULL_SCALE)) ? FULL_SCALE
                                                     : shifted[c][COLOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      prod_q  <= prod_d;
      col_p_q <= data_i.color;
    end
    if (rdy[1] && v_q[0]) begin
      inten_q <= inten_d;
      col_i_q <= col_p_q;
    end
    if (rdy[2] && v_q[1]) begin
      keep_q <= keep_d;
      warm_q <= warm_d;
    end
    if (rdy[3] && v_q[2]) begin
      sat_q <= sat_d;
    end
  end

  assign valid_o          = v_q[3];
  assign data_o.out_red   = sat_q[0];
  assign data_o.out_green = sat_q[1];
  assign data_o.out_blue  = sat_q[2];

  a_inten_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> inten_q <= ONE_Q16)
    else $error("intensity above one");

endmodule

// ===== design/radial_warm_tint_pixel.sv =====
// radial_warm_tint_pixel: top level, configuration registers and the cell row
// depends on rwt_pkg, rwt_front, rwt_root_cell and rwt_back
//
// Takes one pixel word per clock and returns one tinted pixel word per clock,
// in order, while the output is not stalled. Words pass the front stages, the
// square root row and the back stages; the row has one cell per root bit, each
// cell a compare and subtract, and every stage of the pipeline holds its word
// on its own, so a stalled output only stops the input once all stages are
// full. Write center_x, center_y and inv_max_distance only while no pixel is
// in flight.
module radial_warm_tint_pixel
  import rwt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  pixel_in_t               in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output pixel_out_t              out_data_o
);

  localparam int CELLS = ROOT_BITS;

  cfg_t       cfg_q;
  logic       front_rdy;
  logic       back_rdy;

  logic       chain_v   [CELLS+1];
  logic       chain_rdy [CELLS+1];
  root_word_t chain_w   [CELLS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x         <= CENTER_RESET;
      cfg_q.center_y         <= CENTER_RESET;
      cfg_q.inv_max_distance <= INV_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X: cfg_q.center_x         <= cfg_data_i[CENTER_BITS-1:0];
        CFG_CENTER_Y: cfg_q.center_y         <= cfg_data_i[CENTER_BITS-1:0];
        CFG_INV_DIST: cfg_q.inv_max_distance <= cfg_data_i[INV_BITS-1:0];
        default: ;
      endcase
    end
  end

  rwt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (front_rdy),
    .data_i  (in_data_i),
    .valid_o (chain_v[0]),
    .ready_i (chain_rdy[0]),
    .data_o  (chain_w[0])
  );

  assign in_stall_o = !front_rdy;

  // cell i settles root bit CELLS-1-i
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    rwt_root_cell #(
      .BIT (CELLS - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[i]),
      .ready_o (chain_rdy[i]),
      .data_i  (chain_w[i]),
      .valid_o (chain_v[i+1]),
      .ready_i (chain_rdy[i+1]),
      .data_o  (chain_w[i+1])
    );
  end

  rwt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (chain_v[CELLS]),
    .ready_o (back_rdy),
    .data_i  (chain_w[CELLS]),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .data_o  (out_data_o)
  );

  assign chain_rdy[CELLS] = back_rdy;

  // floor square root leaves a remainder of at most twice the root
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_v[CELLS] |-> chain_w[CELLS].rem <= SUM_BITS'({chain_w[CELLS].root, 1'b0}))
    else $error("square root remainder out of range");

  // input can only be held off by a waiting output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // first cell always starts from a zero root
  a_root_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_v[1] && (chain_w[1].root != '0) |->
      chain_w[1].root == ROOT_BITS'(ROOT_BITS'(1) << (CELLS - 1)))
    else $error("first cell root has stray bits");

endmodule

// ===== verif/radial_warm_tint_pixel_test.sv =====
`timescale 1ns / 1ps
// radial_warm_tint_pixel_test: self-checking bench for the radial warm tint pixel block
// needs rwt_pkg and radial_warm_tint_pixel; a bursty driver, a stalling monitor and
// a fixed-point tint predictor whose words are matched in order against the output
module radial_warm_tint_pixel_test;
  import rwt_pkg::*;

  localparam int MAX_COORD    = (1 << COORD_BITS) - 1;
  localparam int MAX_COLOR    = (1 << COLOR_BITS) - 1;
  localparam int DRAIN_CYCLES = 32;
  localparam int LONG_HOLD    = 300;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = CFG_IDX_BITS'(3);

  localparam longint unsigned Q16_ONE   = 65536;
  localparam longint unsigned RED_Q16   = 78643;
  localparam longint unsigned GREEN_Q16 = 39322;
  localparam longint unsigned BLUE_Q16  = 6554;

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    cfg_we_i   = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i  = '0;
  logic [CFG_BITS-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  pixel_in_t               in_data_i  = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  pixel_out_t              out_data_o;

  pixel_in_t  pixels_to_send[$];
  pixel_out_t tinted_due[$];
  cfg_t       tint_cfg;

  int         fail_count  = 0;
  int         burst_left  = 0;
  int         gap_left    = 0;
  int         stall_run   = 0;
  int         hold_asked  = 0;
  int         hold_taken  = 0;
  int         hold_left   = 0;
  bit         steady_send = 1'b0;
  bit         steady_recv = 1'b0;
  pixel_out_t want;

  radial_warm_tint_pixel dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // greatest r with r*r <= v, built one bit at a time
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic logic [COLOR_BITS-1:0] mix_channel(logic [COLOR_BITS-1:0] chan,
                                                        longint unsigned warm_q16,
                                                        longint unsigned weight);
    longint unsigned warm;
    longint unsigned acc;
    longint unsigned level;
    warm  = MAX_COLOR * warm_q16;
    acc   = chan * (Q16_ONE - weight) + ((warm * weight) >> 16);
    level = (acc + 32768) >> 16;
    if (level > MAX_COLOR) level = MAX_COLOR;
    return level[COLOR_BITS-1:0];
  endfunction

  function automatic pixel_out_t tint_pixel(pixel_in_t px);
    longint unsigned pos_x;
    longint unsigned pos_y;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned reach;
    longint unsigned weight;
    pixel_out_t      res;
    pos_x  = {px.column, 4'b0000};
    pos_y  = {px.row, 4'b0000};
    dx     = (pos_x >= tint_cfg.center_x) ? pos_x - tint_cfg.center_x
                                          : tint_cfg.center_x - pos_x;
    dy     = (pos_y >= tint_cfg.center_y) ? pos_y - tint_cfg.center_y
                                          : tint_cfg.center_y - pos_y;
    // distance is q.4, reach is q.16 of the falloff
    reach  = (root_floor(dx * dx + dy * dy) * tint_cfg.inv_max_distance) >> 12;
    weight = (reach < Q16_ONE) ? Q16_ONE - reach : 0;
    res.out_red   = mix_channel(px.in_red, RED_Q16, weight);
    res.out_green = mix_channel(px.in_green, GREEN_Q16, weight);
    res.out_blue  = mix_channel(px.in_blue, BLUE_Q16, weight);
    return res;
  endfunction

  // driver: bursts of words with random gaps, payload held while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tinted_due.push_back(tint_pixel(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0 && !steady_send) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pixels_to_send.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pixels_to_send.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted word, then picks the next stall level
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (tinted_due.size() == 0) begin
          $error("unexpected output word %h", out_data_o);
          fail_count++;
        end else begin
          want = tinted_due.pop_front();
          if (want.out_red !== out_data_o.out_red) begin
            $error("out_red expected %0d got %0d", want.out_red, out_data_o.out_red);
            fail_count++;
          end
          if (want.out_green !== out_data_o.out_green) begin
            $error("out_green expected %0d got %0d", want.out_green, out_data_o.out_green);
            fail_count++;
          end
          if (want.out_blue !== out_data_o.out_blue) begin
            $error("out_blue expected %0d got %0d", want.out_blue, out_data_o.out_blue);
            fail_count++;
          end
        end
      end
      if (hold_taken != hold_asked) begin
        hold_taken  <= hold_asked;
        hold_left   <= LONG_HOLD;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (steady_recv) begin
        out_stall_i <= 1'b0;
      end else if (stall_run > 0) begin
        stall_run <= stall_run - 1;
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        stall_run   <= $urandom_range(0, 7);
      end
    end
  end

  task automatic send_pixel(int col, int row, int red, int green, int blue);
    pixel_in_t px;
    px.column   = COORD_BITS'(col);
    px.row      = COORD_BITS'(row);
    px.in_red   = COLOR_BITS'(red);
    px.in_green = COLOR_BITS'(green);
    px.in_blue  = COLOR_BITS'(blue);
    pixels_to_send.push_back(px);
  endtask

  function automatic int rand_level();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? MAX_COLOR : 0;
    return $urandom_range(0, MAX_COLOR);
  endfunction

  // mostly inside the falloff disc, now and then anywhere on the grid
  function automatic int near_coord(int mid, int spread);
    int c;
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, MAX_COORD);
    c = mid + int'($urandom_range(0, 2 * spread)) - spread;
    if (c < 0) c = 0;
    if (c > MAX_COORD) c = MAX_COORD;
    return c;
  endfunction

  task automatic queue_random(int count, int mid_x, int mid_y, int spread);
    for (int i = 0; i < count; i++)
      send_pixel(near_coord(mid_x, spread), near_coord(mid_y, spread),
                 rand_level(), rand_level(), rand_level());
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixels_to_send.size() != 0 || in_valid_i || tinted_due.size() != 0);
  endtask

  task automatic quiesce();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CENTER_X: tint_cfg.center_x = data[CENTER_BITS-1:0];
      CFG_CENTER_Y: tint_cfg.center_y = data[CENTER_BITS-1:0];
      CFG_INV_DIST: tint_cfg.inv_max_distance = data[INV_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic random_setup_phase(int count, bit pressure, bit calm);
    logic [CENTER_BITS-1:0] cx;
    logic [CENTER_BITS-1:0] cy;
    int                     span;
    cx   = $urandom_range(0, 65535);
    cy   = $urandom_range(0, 65535);
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64) : $urandom_range(64, 5800);
    quiesce();
    write_reg(CFG_CENTER_X, {8'($urandom), cx});
    write_reg(CFG_CENTER_Y, {8'($urandom), cy});
    write_reg(CFG_INV_DIST, CFG_BITS'((1 << 24) / span));
    @(negedge clk_i);
    steady_send = calm || pressure;
    steady_recv = calm || ($urandom_range(0, 3) == 0);
    // receiver holds off while the sender keeps offering, so the pipe backs up
    if (pressure) hold_asked++;
    queue_random(count, cx >> 4, cy >> 4, span);
    wait_drained();
    steady_send = 1'b0;
    steady_recv = 1'b0;
  endtask

  initial begin
    tint_cfg.center_x         = CENTER_RESET;
    tint_cfg.center_y         = CENTER_RESET;
    tint_cfg.inv_max_distance = INV_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: centre of a 4096 square, corner 0,0 just past the falloff, the others just inside
    send_pixel(2048, 2048, 0, 0, 0);
    send_pixel(2048, 2048, MAX_COLOR, MAX_COLOR, MAX_COLOR);
    send_pixel(2048, 2048, 128, 64, 32);
    send_pixel(0, 0, MAX_COLOR, MAX_COLOR, MAX_COLOR);
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(MAX_COORD, MAX_COORD, MAX_COLOR, 0, MAX_COLOR);
    send_pixel(0, MAX_COORD, 170, 85, 15);
    send_pixel(MAX_COORD, 0, 0, MAX_COLOR, 0);
    send_pixel(1024, 2048, 200, 100, 50);
    send_pixel(2048, 3000, 10, 250, 128);
    send_pixel(2049, 2047, MAX_COLOR, MAX_COLOR, 0);
    send_pixel(3500, 600, 1, 254, 127);
    queue_random(200, 2048, 2048, 2900);
    wait_drained();

    // centre on the origin with the steepest falloff
    quiesce();
    write_reg(CFG_CENTER_X, '0);
    write_reg(CFG_CENTER_Y, '0);
    write_reg(CFG_INV_DIST, '1);
    @(negedge clk_i);
    send_pixel(0, 0, MAX_COLOR, MAX_COLOR, MAX_COLOR);
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(1, 0, 90, 180, 45);
    send_pixel(0, 1, MAX_COLOR, 0, MAX_COLOR);
    send_pixel(MAX_COORD, MAX_COORD, 33, 66, 99);
    queue_random(50, 0, 0, 4);
    wait_drained();

    // far corner centre with junk above the register width, zero reciprocal
    quiesce();
    write_reg(CFG_CENTER_X, '1);
    write_reg(CFG_CENTER_Y, '1);
    write_reg(CFG_INV_DIST, '0);
    @(negedge clk_i);
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(MAX_COORD, MAX_COORD, MAX_COLOR, MAX_COLOR, MAX_COLOR);
    send_pixel(2048, 100, 77, 160, 240);
    queue_random(50, MAX_COORD, MAX_COORD, 2000);
    wait_drained();

    // a write to the unused index must leave every register alone
    quiesce();
    write_reg(CFG_CENTER_X, CFG_BITS'(16'h4a38));
    write_reg(CFG_INV_DIST, CFG_BITS'(9000));
    write_reg(CFG_SPARE, CFG_BITS'($urandom));
    @(negedge clk_i);
    queue_random(40, 16'h4a38 >> 4, MAX_COORD, 1900);
    // sender waits for every word to come back before going on
    wait_drained();
    queue_random(40, 16'h4a38 >> 4, MAX_COORD, 1900);
    wait_drained();

    random_setup_phase(100, 1'b0, 1'b1);
    random_setup_phase(100, 1'b0, 1'b0);
    random_setup_phase(150, 1'b1, 1'b0);
    random_setup_phase(100, 1'b0, 1'b0);
    random_setup_phase(100, 1'b0, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && tinted_due.size() == 0) begin
      $display("radial_warm_tint_pixel_test passed");
    end else begin
      $display("radial_warm_tint_pixel_test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("radial_warm_tint_pixel_test failed");
    $finish;
  end

endmodule
